@@ rtl/mgc_pkg.sv @@
// Shared types, codes and the near_pos helper function of the mouse gesture classifier.
// Depends on nothing; every other file imports it.
package mgc_pkg;

    localparam int MAX_BUTTONS = 8;
    localparam int MAX_RESULTS = 6;
    localparam logic [2:0] NO_BUTTON = 3'd5;

    localparam logic [2:0] K_MOVE   = 3'd1;
    localparam logic [2:0] K_VWHEEL = 3'd2;
    localparam logic [2:0] K_HWHEEL = 3'd3;
    localparam logic [2:0] K_DOWN   = 3'd4;
    localparam logic [2:0] K_UP     = 3'd5;

    localparam logic [2:0] G_PRESS   = 3'd0;
    localparam logic [2:0] G_RELEASE = 3'd1;
    localparam logic [2:0] G_CLICK   = 3'd2;
    localparam logic [2:0] G_DOUBLE  = 3'd3;
    localparam logic [2:0] G_LONG    = 3'd4;
    localparam logic [2:0] G_MOVE    = 3'd5;
    localparam logic [2:0] G_SCROLL  = 3'd6;

    localparam logic [1:0] REG_CLICK_HOLD = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_DBL_WINDOW = 2'd2;
    localparam logic [1:0] REG_MOVE_TOL   = 2'd3;

    typedef struct packed {
        logic [8:0] click_hold_limit;
        logic [8:0] long_press_time;
        logic [8:0] double_click_window;
        logic [7:0] move_tolerance;
    } cfg_t;

    typedef struct packed {
        logic [2:0]             g0;
        logic [2:0]             b0;
        logic                   has_release;
        logic [MAX_BUTTONS-1:0] long_mask;
        logic [15:0]            x;
        logic [15:0]            y;
        logic [15:0]            delta;
        logic                   horiz;
        logic [31:0]            t;
    } job_t;

    function automatic logic near_pos(input logic [15:0] ax, input logic [15:0] ay,
                                      input logic [15:0] bx, input logic [15:0] by,
                                      input logic [9:0] tol);
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [16:0] adx;
        logic [16:0] ady;
        dx = 17'($signed(ax)) - 17'($signed(bx));
        dy = 17'($signed(ay)) - 17'($signed(by));
        adx = dx[16] ? 17'(-dx) : 17'(dx);
        ady = dy[16] ? 17'(-dy) : 17'(dy);
        return (adx <= {7'd0, tol}) && (ady <= {7'd0, tol});
    endfunction

endpackage

@@ rtl/mgc_front.sv @@
// Front end: accepts raw pointer beats, keeps per-button records and builds one job each.
// Depends on mgc_pkg.
module mgc_front import mgc_pkg::*; #(
    parameter int NUM_BUTTONS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  logic [2:0]  kind,
    input  logic [2:0]  btn,
    input  logic [15:0] x,
    input  logic [15:0] y,
    input  logic [15:0] d,
    input  logic [31:0] t,
    input  logic        q_full,
    output logic        in_ready,
    output logic        push,
    output job_t        job
);

    logic [NUM_BUTTONS-1:0] held_reg, held_next, lf_reg, lf_next, lcv_reg, lcv_next;
    logic [31:0] pt_reg  [NUM_BUTTONS];
    logic [31:0] pt_next [NUM_BUTTONS];
    logic [15:0] px_reg  [NUM_BUTTONS];
    logic [15:0] px_next [NUM_BUTTONS];
    logic [15:0] py_reg  [NUM_BUTTONS];
    logic [15:0] py_next [NUM_BUTTONS];
    logic [31:0] lct_reg [NUM_BUTTONS];
    logic [31:0] lct_next[NUM_BUTTONS];
    logic [15:0] lcx_reg [NUM_BUTTONS];
    logic [15:0] lcx_next[NUM_BUTTONS];
    logic [15:0] lcy_reg [NUM_BUTTONS];
    logic [15:0] lcy_next[NUM_BUTTONS];

    logic        accept, ev_ok;
    logic [NUM_BUTTONS-1:0] hit;
    logic [31:0] sel_pt, sel_lct, elapsed, since;
    logic [15:0] sel_px, sel_py, sel_lcx, sel_lcy;
    logic        sel_held, sel_lf, sel_lcv, is_click, is_double;
    logic [2:0]  budget, cnt;
    logic [MAX_BUTTONS-1:0] mask;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && ev_ok;

    always_comb begin
        ev_ok = 1'b0;
        case (kind)
            K_MOVE, K_VWHEEL, K_HWHEEL: ev_ok = 1'b1;
            K_DOWN, K_UP: ev_ok = ({29'd0, btn} < NUM_BUTTONS);
            default: ev_ok = 1'b0;
        endcase
    end

    always_comb begin
        sel_pt = '0; sel_lct = '0; sel_px = '0; sel_py = '0; sel_lcx = '0; sel_lcy = '0;
        sel_held = 1'b0; sel_lf = 1'b0; sel_lcv = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            hit[i] = (btn == 3'(i));
            if (hit[i]) begin
                sel_pt = pt_reg[i]; sel_lct = lct_reg[i];
                sel_px = px_reg[i]; sel_py = py_reg[i];
                sel_lcx = lcx_reg[i]; sel_lcy = lcy_reg[i];
                sel_held = held_reg[i]; sel_lf = lf_reg[i]; sel_lcv = lcv_reg[i];
            end
        end
        elapsed = t - sel_pt;
        since   = t - sel_lct;
        is_click = sel_held && !sel_lf && (elapsed < {23'd0, cfg.click_hold_limit})
                   && near_pos(x, y, sel_px, sel_py, {2'd0, cfg.move_tolerance});
        is_double = is_click && sel_lcv && (since < {23'd0, cfg.double_click_window})
                    && near_pos(x, y, sel_lcx, sel_lcy, {cfg.move_tolerance, 2'd0});
    end

    always_comb begin
        held_next = held_reg; lf_next = lf_reg; lcv_next = lcv_reg;
        pt_next = pt_reg; px_next = px_reg; py_next = py_reg;
        lct_next = lct_reg; lcx_next = lcx_reg; lcy_next = lcy_reg;
        job = '0;
        job.x = x; job.y = y; job.t = t;
        job.b0 = btn;
        budget = 3'(MAX_RESULTS - 1);
        case (kind)
            K_MOVE: begin
                job.g0 = G_MOVE; job.b0 = NO_BUTTON;
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    if (held_reg[i] && !lf_reg[i] &&
                        !near_pos(x, y, px_reg[i], py_reg[i], {2'd0, cfg.move_tolerance})) begin
                        held_next[i] = 1'b0;
                        lf_next[i] = 1'b0;
                    end
                end
            end
            K_VWHEEL, K_HWHEEL: begin
                job.g0 = G_SCROLL; job.b0 = NO_BUTTON;
                job.delta = d;
                job.horiz = (kind == K_HWHEEL);
            end
            K_DOWN: begin
                job.g0 = G_PRESS;
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    if (hit[i]) begin
                        held_next[i] = 1'b1; lf_next[i] = 1'b0;
                        pt_next[i] = t; px_next[i] = x; py_next[i] = y;
                    end
                end
            end
            K_UP: begin
                if (is_click) begin
                    job.g0 = is_double ? G_DOUBLE : G_CLICK;
                    job.has_release = 1'b1;
                    budget = 3'(MAX_RESULTS - 2);
                end else begin
                    job.g0 = G_RELEASE;
                end
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    if (hit[i]) begin
                        held_next[i] = 1'b0; lf_next[i] = 1'b0;
                        if (is_double) begin
                            lcv_next[i] = 1'b0; lct_next[i] = '0;
                        end else if (is_click) begin
                            lcv_next[i] = 1'b1; lct_next[i] = t;
                            lcx_next[i] = x; lcy_next[i] = y;
                        end
                    end
                end
            end
            default: job.g0 = G_MOVE;
        endcase
        cnt = '0;
        mask = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (held_next[i] && !lf_next[i] && (cnt < budget) &&
                ((t - pt_next[i]) >= {23'd0, cfg.long_press_time})) begin
                mask[i] = 1'b1;
                lf_next[i] = 1'b1;
                cnt = cnt + 3'd1;
            end
        end
        job.long_mask = mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            lf_reg   <= '0;
            lcv_reg  <= '0;
        end else if (push) begin
            held_reg <= held_next;
            lf_reg   <= lf_next;
            lcv_reg  <= lcv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            pt_reg <= pt_next; px_reg <= px_next; py_reg <= py_next;
            lct_reg <= lct_next; lcx_reg <= lcx_next; lcy_reg <= lcy_next;
        end
    end

    a_lf_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (lf_reg & ~held_reg) == '0) else $error("long-press flag set on a released button");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push) else $error("job pushed into a full queue");
    a_press_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && kind == K_DOWN) |=> (held_reg != '0)) else $error("press not recorded");

endmodule

@@ rtl/mgc_queue.sv @@
// Two-entry job queue between the front end and the result sequencer.
// Depends on mgc_pkg.
module mgc_queue import mgc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    job_t       mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= push_job;
    end

endmodule

@@ rtl/mgc_back.sv @@
// Result sequencer: expands each queued job into result beats, one per cycle unless the output stalls.
// Depends on mgc_pkg.
module mgc_back import mgc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  job_t        q_head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,
    output logic [3:0]  m_tuser,
    output logic        m_tlast
);

    typedef enum logic [1:0] {PH_PRI, PH_REL, PH_LNG} phase_t;

    phase_t phase_reg, phase_next;
    logic   cur_valid_reg;
    job_t   cur_reg;
    logic [MAX_BUTTONS-1:0] mask_reg, mask_next, low_one;
    logic [2:0] low_idx, g, b;
    logic       emit, fin, load, m_tvalid_reg;
    logic [15:0] dlt;
    logic        hz;

    assign emit = cur_valid_reg && (!m_tvalid_reg || m_tready);
    assign load = (!cur_valid_reg || (emit && fin)) && !q_empty;
    assign pop  = load;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        low_idx = '0;
        low_one = '0;
        for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                low_idx = 3'(i);
                low_one = MAX_BUTTONS'(1) << i;
            end
        end
    end

    always_comb begin
        g = cur_reg.g0; b = cur_reg.b0; dlt = '0; hz = 1'b0;
        mask_next = mask_reg; phase_next = phase_reg; fin = 1'b0;
        case (phase_reg)
            PH_PRI: begin
                dlt = cur_reg.delta; hz = cur_reg.horiz;
                fin = !cur_reg.has_release && (mask_reg == '0);
                phase_next = cur_reg.has_release ? PH_REL : PH_LNG;
            end
            PH_REL: begin
                g = G_RELEASE;
                fin = (mask_reg == '0);
                phase_next = PH_LNG;
            end
            PH_LNG: begin
                g = G_LONG; b = low_idx;
                mask_next = mask_reg & ~low_one;
                fin = (mask_next == '0);
            end
            default: fin = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PH_PRI;
            mask_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (load) begin
                cur_valid_reg <= 1'b1;
                cur_reg       <= q_head;
                phase_reg     <= PH_PRI;
                mask_reg      <= q_head.long_mask;
            end else if (emit && fin) begin
                cur_valid_reg <= 1'b0;
            end else if (emit) begin
                phase_reg <= phase_next;
                mask_reg  <= mask_next;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
                m_tdata <= {5'd0, cur_reg.t, dlt, cur_reg.y, cur_reg.x, b};
                m_tuser <= {hz, g};
                m_tlast <= fin;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    a_lng_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_valid_reg && phase_reg == PH_LNG) |-> (mask_reg != '0))
        else $error("long-press phase without pending buttons");
    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty) else $error("pop from an empty queue");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid_reg) else $error("emitted result not presented");

endmodule

@@ rtl/mouse_gesture_classifier_core.sv @@
// Mouse gesture classifier top level: APB register file, front end, job queue, sequencer.
// Depends on mgc_pkg, mgc_front, mgc_queue and mgc_back.
//
// Raw pointer events enter as beats on the s_ channel (kind in s_tuser) and the
// logical gestures leave as beats on the m_ channel, m_tlast marking the final
// gesture caused by one event. Ignored kinds and out-of-range buttons are taken
// and give no beat. The front end takes an event and updates the press and click
// records at once, so events may arrive every cycle while the two-entry job queue
// has room. The sequencer sends one gesture per cycle unless the output stalls;
// an event gives 1 to 6 gestures, the first passing through the job queue, the
// current-job and output registers. When the receiver stalls, the output register
// holds, then the sequencer and the queue fill, then s_tready falls. Reset clears
// the button flags and restores the register defaults. Registers sit at byte
// addresses 0, 4, 8 and 12; the user must write them only while idle (unenforced).
module mouse_gesture_classifier_core import mgc_pkg::*; #(
    parameter int NUM_BUTTONS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // button[2:0], pos_x[18:3], pos_y[34:19], wheel_delta[50:35], time_ms[82:51]
    input  logic [87:0] s_tdata,
    // event_kind[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // which_button[2:0], out_x[18:3], out_y[34:19], out_delta[50:35], out_time[82:51]
    output logic [87:0] m_tdata,
    // gesture[2:0], is_horizontal[3]
    output logic [3:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg_reg;
    logic push, pop, q_full, q_empty;
    job_t job, head;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.click_hold_limit    <= 9'd500;
            cfg_reg.long_press_time     <= 9'd500;
            cfg_reg.double_click_window <= 9'd500;
            cfg_reg.move_tolerance      <= 8'd4;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_CLICK_HOLD: cfg_reg.click_hold_limit    <= pwdata[8:0];
                REG_LONG_PRESS: cfg_reg.long_press_time     <= pwdata[8:0];
                REG_DBL_WINDOW: cfg_reg.double_click_window <= pwdata[8:0];
                REG_MOVE_TOL:   cfg_reg.move_tolerance      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CLICK_HOLD: prdata = {23'd0, cfg_reg.click_hold_limit};
            REG_LONG_PRESS: prdata = {23'd0, cfg_reg.long_press_time};
            REG_DBL_WINDOW: prdata = {23'd0, cfg_reg.double_click_window};
            REG_MOVE_TOL:   prdata = {24'd0, cfg_reg.move_tolerance};
            default:        prdata = '0;
        endcase
    end

    mgc_front #(.NUM_BUTTONS(NUM_BUTTONS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .in_valid(s_tvalid), .kind(s_tuser), .btn(s_tdata[2:0]),
        .x(s_tdata[18:3]), .y(s_tdata[34:19]), .d(s_tdata[50:35]), .t(s_tdata[82:51]),
        .q_full(q_full), .in_ready(s_tready), .push(push), .job(job)
    );

    mgc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_job(job),
        .pop(pop), .full(q_full), .empty(q_empty), .head(head)
    );

    mgc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_empty(q_empty), .q_head(head), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for mouse_gesture_classifier_core: directed and random pointer events,
// each gesture beat checked against a local predictor. Depends on mgc_pkg and the RTL.
module testbench;
    import mgc_pkg::*;

    typedef struct {
        logic [2:0]  gesture;
        logic [2:0]  button;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] delta;
        logic        horiz;
        logic [31:0] t;
        logic        last;
    } gesture_t;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  button;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] delta;
        logic [31:0] t;
        logic [2:0]  first_gesture;
    } row_t;

    localparam int NBTN = 5;
    localparam logic [2:0] NO_CHECK = 3'd7;
    localparam logic [2:0] K_IGNORED = 3'd0;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mouse_gesture_classifier_core #(.NUM_BUTTONS(NBTN)) u_top (.*);

    logic [8:0]  hold_limit;
    logic [8:0]  long_time;
    logic [8:0]  dbl_window;
    logic [7:0]  tolerance;
    logic        held [NBTN];
    logic        long_done [NBTN];
    logic [31:0] press_t [NBTN];
    logic [15:0] press_px [NBTN];
    logic [15:0] press_py [NBTN];
    logic [31:0] click_t [NBTN];
    logic [15:0] click_px [NBTN];
    logic [15:0] click_py [NBTN];
    logic        click_ok [NBTN];

    gesture_t    gesture_q[$];
    logic [2:0]  typed_first_q[$];
    logic [2:0]  cur_check;
    logic        run_start;
    int          errors;
    int          stall_count;
    int          s_idle_pct;
    int          m_idle_pct;
    int          items;
    logic [31:0] cur_t;
    row_t        rows[$];

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic logic is_near(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx,
                                     logic [15:0] by, int tol);
        int dx;
        int dy;
        dx = int'($signed(ax)) - int'($signed(bx));
        dy = int'($signed(ay)) - int'($signed(by));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return dx <= tol && dy <= tol;
    endfunction

    function automatic void add_gesture(ref int n, input logic [2:0] g, input logic [2:0] b,
                                        input logic [15:0] x, input logic [15:0] y,
                                        input logic [15:0] d, input logic h,
                                        input logic [31:0] t);
        gesture_t r;
        if (n >= MAX_RESULTS) return;
        r = '{g, b, x, y, d, h, t, 1'b0};
        gesture_q.push_back(r);
        n++;
    endfunction

    // Updates the button records and queues the gestures one event should give.
    function automatic int classify_event(logic [2:0] kind, logic [2:0] b, logic [15:0] x,
                                          logic [15:0] y, logic [15:0] d, logic [31:0] t);
        int n;
        logic [31:0] elapsed;
        logic [31:0] since;
        n = 0;
        if (kind == K_IGNORED || kind > K_UP) return 0;
        if ((kind == K_DOWN || kind == K_UP) && b >= NBTN) return 0;
        case (kind)
            K_MOVE: begin
                for (int i = 0; i < NBTN; i++) begin
                    if (held[i] && !long_done[i] &&
                        !is_near(x, y, press_px[i], press_py[i], int'(tolerance))) begin
                        held[i] = 1'b0;
                        long_done[i] = 1'b0;
                    end
                end
                add_gesture(n, G_MOVE, NO_BUTTON, x, y, 16'd0, 1'b0, t);
            end
            K_VWHEEL, K_HWHEEL: begin
                add_gesture(n, G_SCROLL, NO_BUTTON, x, y, d, kind == K_HWHEEL, t);
            end
            K_DOWN: begin
                held[b] = 1'b1;
                long_done[b] = 1'b0;
                press_t[b] = t;
                press_px[b] = x;
                press_py[b] = y;
                add_gesture(n, G_PRESS, b, x, y, 16'd0, 1'b0, t);
            end
            default: begin
                if (held[b] && !long_done[b]) begin
                    elapsed = t - press_t[b];
                    if (elapsed < hold_limit && is_near(x, y, press_px[b], press_py[b],
                                                        int'(tolerance))) begin
                        since = t - click_t[b];
                        if (click_ok[b] && since < dbl_window &&
                            is_near(x, y, click_px[b], click_py[b], 4 * int'(tolerance))) begin
                            add_gesture(n, G_DOUBLE, b, x, y, 16'd0, 1'b0, t);
                            click_ok[b] = 1'b0;
                            click_t[b] = '0;
                        end else begin
                            add_gesture(n, G_CLICK, b, x, y, 16'd0, 1'b0, t);
                            click_ok[b] = 1'b1;
                            click_t[b] = t;
                            click_px[b] = x;
                            click_py[b] = y;
                        end
                    end
                end
                held[b] = 1'b0;
                long_done[b] = 1'b0;
                add_gesture(n, G_RELEASE, b, x, y, 16'd0, 1'b0, t);
            end
        endcase
        for (int i = 0; i < NBTN; i++) begin
            if (n >= MAX_RESULTS) break;
            if (!held[i] || long_done[i]) continue;
            if (t - press_t[i] >= long_time) begin
                long_done[i] = 1'b1;
                add_gesture(n, G_LONG, i[2:0], x, y, 16'd0, 1'b0, t);
            end
        end
        if (n > 0) gesture_q[gesture_q.size() - 1].last = 1'b1;
        return n;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        gesture_t e;
        int n;
        logic [2:0] first_g;
        logic accepted;
        if (aresetn) begin
            accepted = 1'b0;
            if (s_tvalid && s_tready) begin
                accepted = 1'b1;
                n = classify_event(s_tuser, s_tdata[2:0], s_tdata[18:3], s_tdata[34:19],
                                   s_tdata[50:35], s_tdata[82:51]);
                if (n > 0) typed_first_q.push_back(cur_check);
            end
            if (m_tvalid && m_tready) begin
                accepted = 1'b1;
                if (gesture_q.size() == 0) begin
                    $error("gesture beat with none expected");
                    errors++;
                end else begin
                    e = gesture_q.pop_front();
                    if (run_start && typed_first_q.size() > 0) begin
                        first_g = typed_first_q.pop_front();
                        if (first_g != NO_CHECK)
                            check_field("first gesture", 32'(first_g), 32'(m_tuser[2:0]));
                    end
                    check_field("gesture", 32'(e.gesture), 32'(m_tuser[2:0]));
                    check_field("which_button", 32'(e.button), 32'(m_tdata[2:0]));
                    check_field("out_x", 32'(e.x), 32'(m_tdata[18:3]));
                    check_field("out_y", 32'(e.y), 32'(m_tdata[34:19]));
                    check_field("out_delta", 32'(e.delta), 32'(m_tdata[50:35]));
                    check_field("is_horizontal", 32'(e.horiz), 32'(m_tuser[3]));
                    check_field("out_time", e.t, m_tdata[82:51]);
                    check_field("last_of_run", 32'(e.last), 32'(m_tlast));
                end
                run_start <= m_tlast;
            end
            stall_count <= accepted ? 0 : stall_count + 1;
            if (stall_count > 5000) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    task automatic send_event(logic [2:0] kind, logic [2:0] b, logic [15:0] x, logic [15:0] y,
                              logic [15:0] d, logic [31:0] t, logic [2:0] first_g);
        @(negedge aclk);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {5'd0, t, d, y, x, b};
        cur_check <= first_g;
        do @(posedge aclk); while (!s_tready);
        if (!(kind == K_IGNORED || kind > K_UP || ((kind == K_DOWN || kind == K_UP) && b >= NBTN)))
            items++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (gesture_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_CLICK_HOLD: hold_limit = value[8:0];
            REG_LONG_PRESS: long_time = value[8:0];
            REG_DBL_WINDOW: dbl_window = value[8:0];
            default:        tolerance = value[7:0];
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(int h, int l, int w, int tol);
        write_reg(REG_CLICK_HOLD, h);
        write_reg(REG_LONG_PRESS, l);
        write_reg(REG_DBL_WINDOW, w);
        write_reg(REG_MOVE_TOL, tol);
    endtask

    function automatic void row(logic [2:0] k, logic [2:0] b, logic [15:0] x, logic [15:0] y,
                                logic [15:0] d, logic [31:0] t, logic [2:0] g);
        rows.push_back('{k, b, x, y, d, t, g});
    endfunction

    function automatic logic [15:0] jitter(logic [15:0] v, int span);
        return v + 16'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic random_burst(int target);
        logic [2:0]  b;
        logic [15:0] x;
        logic [15:0] y;
        int          span;
        int          pick;
        target = items + target;
        while (items < target) begin
            pick = $urandom_range(0, 9);
            b = 3'($urandom_range(0, NBTN - 1));
            x = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
            y = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
            span = int'(tolerance) + 2;
            cur_t += $urandom_range(0, 700);
            if (pick <= 5) begin
                repeat ($urandom_range(1, 2)) begin
                    send_event(K_DOWN, b, x, y, 16'($urandom), cur_t, NO_CHECK);
                    if ($urandom_range(0, 2) == 0) begin
                        cur_t += $urandom_range(0, 100);
                        send_event(K_MOVE, b, jitter(x, span), jitter(y, span), 16'd0, cur_t,
                                   NO_CHECK);
                    end
                    cur_t += $urandom_range(0, 600);
                    send_event(K_UP, b, jitter(x, span), jitter(y, span), 16'($urandom), cur_t,
                               NO_CHECK);
                    cur_t += $urandom_range(0, 600);
                end
            end else if (pick == 6) begin
                send_event(K_DOWN, b, x, y, 16'd0, cur_t, NO_CHECK);
                cur_t += $urandom_range(0, 1000);
                send_event(K_MOVE, b, jitter(x, span), jitter(y, span), 16'd0, cur_t,
                           NO_CHECK);
                if ($urandom_range(0, 1)) begin
                    cur_t += $urandom_range(0, 600);
                    send_event(K_UP, b, x, y, 16'd0, cur_t, NO_CHECK);
                end
            end else if (pick == 7) begin
                send_event(3'($urandom_range(K_MOVE, K_HWHEEL)), 3'($urandom), x, y,
                           16'($urandom), cur_t, NO_CHECK);
            end else if (pick == 8) begin
                send_event(3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), $urandom, NO_CHECK);
            end else begin
                cur_t = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 600);
            end
        end
    endtask

    initial begin
        errors = 0;
        stall_count = 0;
        items = 0;
        run_start = 1'b1;
        cur_check = NO_CHECK;
        s_idle_pct = 18;
        m_idle_pct = 60;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_limit = 9'd500;
        long_time = 9'd500;
        dbl_window = 9'd500;
        tolerance = 8'd4;
        for (int i = 0; i < NBTN; i++) begin
            held[i] = 1'b0;
            long_done[i] = 1'b0;
            press_t[i] = '0;
            press_px[i] = '0;
            press_py[i] = '0;
            click_t[i] = '0;
            click_px[i] = '0;
            click_py[i] = '0;
            click_ok[i] = 1'b0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        row(K_IGNORED, 3'd0, 16'd0, 16'd0, 16'd0, 32'd50, NO_CHECK);
        row(K_MOVE, 3'd7, 16'h7FFF, 16'h8000, 16'hFFFF, 32'd100, G_MOVE);
        row(K_VWHEEL, 3'd0, 16'h8000, 16'h7FFF, 16'h8000, 32'd110, G_SCROLL);
        row(K_HWHEEL, 3'd0, 16'hFFFF, 16'd0, 16'h7FFF, 32'd120, G_SCROLL);
        row(K_DOWN, 3'd0, 16'd10, 16'd10, 16'd0, 32'd1000, G_PRESS);
        row(K_UP, 3'd0, 16'd12, 16'd12, 16'd0, 32'd1100, G_CLICK);
        row(K_DOWN, 3'd0, 16'd10, 16'd10, 16'd0, 32'd1200, G_PRESS);
        row(K_UP, 3'd0, 16'd10, 16'd10, 16'd0, 32'd1300, G_DOUBLE);
        row(K_DOWN, 3'd1, 16'd10, 16'd10, 16'd0, 32'd2000, G_PRESS);
        row(K_MOVE, 3'd0, 16'd30, 16'd30, 16'd0, 32'd2010, G_MOVE);
        row(K_UP, 3'd1, 16'd30, 16'd30, 16'd0, 32'd2020, G_RELEASE);
        row(K_DOWN, 3'd2, 16'd10, 16'd10, 16'd0, 32'd3000, G_PRESS);
        row(K_MOVE, 3'd0, 16'd10, 16'd10, 16'd0, 32'd3600, G_MOVE);
        row(K_UP, 3'd2, 16'd10, 16'd10, 16'd0, 32'd3700, G_RELEASE);
        row(K_DOWN, 3'd7, 16'd0, 16'd0, 16'd0, 32'd3800, NO_CHECK);
        row(3'd6, 3'd0, 16'd0, 16'd0, 16'd0, 32'd3900, NO_CHECK);
        row(3'd7, 3'd0, 16'd0, 16'd0, 16'd0, 32'd3950, NO_CHECK);
        row(K_DOWN, 3'd4, 16'd5, 16'd5, 16'd0, 32'hFFFF_FF00, G_PRESS);
        row(K_UP, 3'd4, 16'd5, 16'd5, 16'd0, 32'h0000_0010, G_CLICK);
        row(K_DOWN, 3'd3, 16'd0, 16'd0, 16'd0, 32'd5000, G_PRESS);
        row(K_DOWN, 3'd3, 16'd0, 16'd0, 16'd0, 32'd5400, G_PRESS);
        row(K_UP, 3'd3, 16'd0, 16'd0, 16'd0, 32'd5450, G_CLICK);
        for (int i = 0; i < NBTN; i++)
            row(K_DOWN, i[2:0], 16'd0, 16'd0, 16'd0, 32'd6000, G_PRESS);
        row(K_MOVE, 3'd0, 16'd0, 16'd0, 16'd0, 32'd7000, G_MOVE);
        foreach (rows[i])
            send_event(rows[i].kind, rows[i].button, rows[i].x, rows[i].y, rows[i].delta,
                       rows[i].t, rows[i].first_gesture);
        drain();

        cur_t = 32'd10000;
        for (int i = 0; i < NBTN; i++)
            send_event(K_UP, i[2:0], 16'd0, 16'd0, 16'd0, cur_t, NO_CHECK);
        random_burst(50);
        drain();
        set_config(500, 500, 500, 255);
        s_idle_pct = 60;
        m_idle_pct = 18;
        random_burst(70);
        drain();
        set_config(0, 0, 0, 0);
        s_idle_pct = 0;
        m_idle_pct = 0;
        random_burst(50);
        drain();
        set_config($urandom_range(50, 450), $urandom_range(300, 500), $urandom_range(100, 500),
                   $urandom_range(1, 20));
        s_idle_pct = 18;
        m_idle_pct = 60;
        random_burst(60);
        drain();

        if (errors == 0 && gesture_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/mgc_pkg.sv
rtl/mgc_front.sv
rtl/mgc_queue.sv
rtl/mgc_back.sv
rtl/mouse_gesture_classifier_core.sv
dv/testbench.sv
